// File: design/ctc_pkg.sv
// Shared types and constants for the compact target converter.
package ctc_pkg;

    // Bytes of the big value that the conversion uses (4 to 32).
    localparam int VALUE_BYTES = 32;
    // Bytes carried on the ports; fixed by the four 64-bit value words.
    localparam int FULL_BYTES  = 32;
    localparam int VALUE_W     = FULL_BYTES * 8;
    localparam int WORD_W      = 64;
    localparam int COMPACT_W   = 32;
    localparam int EXP_W       = 8;
    localparam int MANT_W      = 24;
    localparam int IDX_W       = $clog2(FULL_BYTES);
    localparam int DATA_W      = COMPACT_W + VALUE_W;

    typedef enum logic {
        REQ_DECODE = 1'b0,
        REQ_ENCODE = 1'b1
    } req_type_t;

    typedef struct packed {
        req_type_t              req_type;
        logic [COMPACT_W-1:0]   compact;
        logic [VALUE_W-1:0]     value;
    } ctc_req_t;

    typedef struct packed {
        logic [COMPACT_W-1:0]   compact;
        logic [VALUE_W-1:0]     value;
        logic                   too_big;
        logic                   exact;
    } ctc_result_t;

endpackage

// File: design/ctc_convert.sv
// Combinational decode and encode of one compact target request.
module ctc_convert
    import ctc_pkg::*;
(
    input  ctc_req_t    req,
    output ctc_result_t res
);

    // Decode path.
    logic [EXP_W-1:0]     d_exp_raw;
    logic [MANT_W-1:0]    d_mant_raw;
    logic [EXP_W-1:0]     d_exp;
    logic [MANT_W-1:0]    d_mant;
    logic                 d_too_big;
    logic                 d_zero;
    logic [COMPACT_W-1:0] d_word;

    // Encode path.
    logic [7:0]           vbyte [FULL_BYTES];
    logic                 e_found;
    logic [IDX_W-1:0]     e_top_idx;
    logic                 e_top_sign;
    logic [EXP_W-1:0]     e_len;
    logic [MANT_W-1:0]    e_mant;
    logic                 e_inexact;
    logic                 e_too_big;
    logic [COMPACT_W-1:0] e_word;

    // Result.
    logic [COMPACT_W-1:0] word;
    logic [EXP_W-1:0]     x_exp;
    logic [MANT_W-1:0]    x_mant;
    logic [VALUE_W-1:0]   x_value;

    always_comb begin
        d_exp_raw  = req.compact[COMPACT_W-1 -: EXP_W];
        d_mant_raw = req.compact[MANT_W-1:0];
        d_too_big  = (d_exp_raw > EXP_W'(VALUE_BYTES)) ||
                     ((d_exp_raw == EXP_W'(VALUE_BYTES)) && d_mant_raw[MANT_W-1]);
        // A set top mantissa bit would read as a sign, so move one byte up.
        if (d_mant_raw[MANT_W-1]) begin
            d_mant = {8'h00, d_mant_raw[MANT_W-1:8]};
            d_exp  = d_exp_raw + EXP_W'(1);
        end else begin
            d_mant = d_mant_raw;
            d_exp  = d_exp_raw;
        end
        d_zero = (d_exp == '0) || (d_mant == '0) ||
                 ((d_exp == EXP_W'(1)) && (d_mant[23:16] == 8'h00)) ||
                 ((d_exp == EXP_W'(2)) && (d_mant[23:8] == 16'h0000));
        if (d_too_big || d_zero) begin
            d_word = '0;
        end else begin
            d_word = {d_exp, d_mant};
        end
    end

    always_comb begin
        e_found    = 1'b0;
        e_top_idx  = '0;
        e_top_sign = 1'b0;
        for (int p = 0; p < FULL_BYTES; p++) begin
            vbyte[p] = (p < VALUE_BYTES) ? req.value[8*p +: 8] : 8'h00;
        end
        // Highest nonzero byte wins.
        for (int p = 0; p < FULL_BYTES; p++) begin
            if (vbyte[p] != 8'h00) begin
                e_found    = 1'b1;
                e_top_idx  = IDX_W'(p);
                e_top_sign = vbyte[p][7];
            end
        end
        e_len = e_found ? (EXP_W'(e_top_idx) + EXP_W'(1) + EXP_W'(e_top_sign)) : '0;
        e_too_big = (e_len > EXP_W'(VALUE_BYTES));

        e_mant    = '0;
        e_inexact = 1'b0;
        for (int p = 0; p < FULL_BYTES; p++) begin
            if (EXP_W'(p + 1) == e_len) begin
                e_mant[23:16] = vbyte[p];
            end
            if (EXP_W'(p + 2) == e_len) begin
                e_mant[15:8] = vbyte[p];
            end
            if (EXP_W'(p + 3) == e_len) begin
                e_mant[7:0] = vbyte[p];
            end
            if ((EXP_W'(p + 3) < e_len) && (vbyte[p] != 8'h00)) begin
                e_inexact = 1'b1;
            end
        end
        e_word = e_too_big ? '0 : {e_len, e_mant};
    end

    always_comb begin
        unique case (req.req_type)
            REQ_ENCODE: begin
                word        = e_word;
                res.too_big = e_too_big;
                res.exact   = !e_too_big && !e_inexact;
            end
            default: begin
                word        = d_word;
                res.too_big = d_too_big;
                res.exact   = 1'b1;
            end
        endcase

        // Expand the normalized word: the mantissa lands at bytes exp-1 down to exp-3.
        x_exp  = word[COMPACT_W-1 -: EXP_W];
        x_mant = word[MANT_W-1:0];
        for (int p = 0; p < FULL_BYTES; p++) begin
            if (p >= VALUE_BYTES) begin
                x_value[8*p +: 8] = 8'h00;
            end else if (x_exp == EXP_W'(p + 1)) begin
                x_value[8*p +: 8] = x_mant[23:16];
            end else if (x_exp == EXP_W'(p + 2)) begin
                x_value[8*p +: 8] = x_mant[15:8];
            end else if (x_exp == EXP_W'(p + 3)) begin
                x_value[8*p +: 8] = x_mant[7:0];
            end else begin
                x_value[8*p +: 8] = 8'h00;
            end
        end
        res.compact = word;
        res.value   = x_value;
    end

endmodule

// File: design/compact_target_converter_core.sv
// Top level of the compact target converter: stream ports, input and result registers.
//
// Converts between a 256-bit target and its 32-bit compact form (exponent in bits 31..24,
// mantissa in bits 23..0). tuser selects the direction: 0 decodes the compact word in
// tdata[31:0], 1 encodes the value in tdata[287:32]. Every request gives exactly one
// result holding the normalized compact word, its expansion and the too_big and exact
// flags. The block takes one request per cycle while the input side is not stalled;
// an accepted transfer passes through the input register and then the result register,
// with the whole conversion done by the logic between them. Backpressure on the result
// side stalls the input side only once both registers are full.
module compact_target_converter_core
    import ctc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // compact_in [31:0], value_in_w3 [95:32], value_in_w2 [159:96],
    // value_in_w1 [223:160], value_in_w0 [287:224]
    input  logic [DATA_W-1:0] s_axis_tdata,
    // req_type [0]
    input  logic              s_axis_tuser,

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // compact_out [31:0], value_out_w3 [95:32], value_out_w2 [159:96],
    // value_out_w1 [223:160], value_out_w0 [287:224]
    output logic [DATA_W-1:0] m_axis_tdata,
    // too_big [0], exact [1]
    output logic [1:0]        m_axis_tuser
);

    logic        in_valid_reg;
    logic        in_valid_next;
    ctc_req_t    in_req_reg;
    ctc_req_t    in_req_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    ctc_result_t out_res_reg;
    ctc_result_t conv_res;
    logic        adv_out;

    assign adv_out       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv_out;

    always_comb begin
        in_req_next.req_type = req_type_t'(s_axis_tuser);
        in_req_next.compact  = s_axis_tdata[COMPACT_W-1:0];
        // The value words arrive most significant first; reorder into one little-endian word.
        in_req_next.value    = {s_axis_tdata[COMPACT_W +: WORD_W],
                                s_axis_tdata[COMPACT_W + WORD_W +: WORD_W],
                                s_axis_tdata[COMPACT_W + 2*WORD_W +: WORD_W],
                                s_axis_tdata[COMPACT_W + 3*WORD_W +: WORD_W]};
        in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        if (adv_out) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    ctc_convert u_convert (
        .req (in_req_reg),
        .res (conv_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_req_reg <= in_req_next;
        end
        if (adv_out) begin
            out_res_reg <= conv_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.value[0 +: WORD_W],
                            out_res_reg.value[WORD_W +: WORD_W],
                            out_res_reg.value[2*WORD_W +: WORD_W],
                            out_res_reg.value[3*WORD_W +: WORD_W],
                            out_res_reg.compact};
    assign m_axis_tuser  = {out_res_reg.exact, out_res_reg.too_big};

    // An overflowing request must come out as all zeros.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_res_reg.too_big) |->
            (out_res_reg.compact == '0) && (out_res_reg.value == '0))
        else $error("too_big result carries nonzero data");

    // A normalized compact word never has the mantissa sign bit set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !out_res_reg.compact[MANT_W-1])
        else $error("compact result has mantissa bit 23 set");

    // The exponent of a delivered word stays within the value width.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (out_res_reg.compact[COMPACT_W-1 -: EXP_W] <= EXP_W'(VALUE_BYTES)))
        else $error("compact result exponent beyond value width");

    // A zero exponent means the word and its expansion are both zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (out_res_reg.compact[COMPACT_W-1 -: EXP_W] == '0)) |->
            (out_res_reg.compact == '0) && (out_res_reg.value == '0))
        else $error("zero exponent with nonzero mantissa or value");

    // The input side stalls only when both registers hold items and the output is blocked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while the pipeline can move");

endmodule
